FILE: src/bdec_pkg.sv
// Shared types and constants of the base64 stream decoder.
package bdec_pkg;

  localparam int unsigned CapW        = 15;
  localparam int unsigned FifoDepthDef = 4;
  localparam logic [CapW-1:0] CapReset = 15'h7FFF;

  typedef struct packed {
    logic [23:0]     chunk;
    logic [1:0]      nbytes;
    logic            status;
    logic            err;
    logic [CapW-1:0] count;
  } job_t;

endpackage

FILE: src/bdec_front.sv
// Front end: classifies characters, tracks quanta and emits a job for each completed quantum or final character.
module bdec_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bdec_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_code_i,
  input  logic                     final_char_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output bdec_pkg::job_t           job_o
);
  import bdec_pkg::*;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  logic [CapW-1:0] cap_q;
  logic [1:0]      pos_q, pos_d;
  logic [17:0]     acc_q, acc_d;
  logic [1:0]      pad_q, pad_d;
  logic [CapW-1:0] bw_q, bw_d;
  logic            error_q, error_d;

  logic            accept;
  logic            is_pad;
  logic [6:0]      sx;
  logic            err_c;
  logic            err_any;
  logic [1:0]      pad_n;
  logic [1:0]      nb;
  logic [1:0]      nb_emit;
  logic [CapW:0]   sum;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_pad     = (char_code_i == CharPad);
  assign sx         = sextet_of(char_code_i);
  assign err_c      = is_pad ? (pos_q < 2'd2) : (!sx[6] || pad_q != 2'd0);
  assign pad_n      = (is_pad && pos_q >= 2'd2) ? pad_q + 2'd1 : pad_q;
  assign nb         = (pad_n >= 2'd2) ? 2'd1 : 2'd3 - pad_n;
  assign sum        = {1'b0, bw_q} + {{(CapW-1){1'b0}}, nb};

  always_comb begin
    pos_d   = pos_q;
    acc_d   = acc_q;
    pad_d   = pad_q;
    bw_d    = bw_q;
    err_any = 1'b0;
    nb_emit = 2'd0;
    if (!error_q) begin
      if (err_c) begin
        err_any = 1'b1;
      end else if (pos_q != 2'd3) begin
        acc_d = {acc_q[11:0], sx[5:0] & {6{!is_pad}}};
        pos_d = pos_q + 2'd1;
        pad_d = pad_n;
        err_any = final_char_i;
      end else begin
        if (pad_n != 2'd0 && !final_char_i) begin
          err_any = 1'b1;
        end else if (sum > {1'b0, cap_q}) begin
          err_any = 1'b1;
        end else begin
          nb_emit = nb;
          bw_d    = sum[CapW-1:0];
        end
        pos_d = 2'd0;
        acc_d = '0;
        pad_d = 2'd0;
      end
    end
    error_d = error_q | err_any;

    job_o.chunk  = {acc_q, sx[5:0] & {6{!is_pad}}};
    job_o.nbytes = nb_emit;
    job_o.status = final_char_i;
    job_o.err    = error_d;
    job_o.count  = error_d ? '0 : bw_d;
    push_o       = accept && (nb_emit != 2'd0 || final_char_i);

    if (final_char_i) begin
      pos_d   = 2'd0;
      acc_d   = '0;
      pad_d   = 2'd0;
      bw_d    = '0;
      error_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      pos_q   <= '0;
      acc_q   <= '0;
      pad_q   <= '0;
      bw_q    <= '0;
      error_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q   <= pos_d;
        acc_q   <= acc_d;
        pad_q   <= pad_d;
        bw_q    <= bw_d;
        error_q <= error_d;
      end
    end
  end

endmodule

FILE: src/bdec_fifo.sv
// Job queue between front and back end.
module bdec_fifo #(
  parameter int unsigned Depth = bdec_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bdec_pkg::job_t wdata_i,
  input  logic           pop_i,
  output bdec_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import bdec_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= advance(wr_q);
      end
      if (pop_i) begin
        rd_q <= advance(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/bdec_back.sv
// Back end: expands queued jobs into data and status words behind an output register.
module bdec_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdec_pkg::job_t            job_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      is_status_o,
  output logic                      decode_error_o,
  output logic [bdec_pkg::CapW-1:0] byte_count_o,
  output logic                      run_end_o
);
  import bdec_pkg::*;

  logic [1:0]      idx_q;
  logic            valid_q;
  logic [7:0]      byte_q;
  logic            status_q;
  logic            err_q;
  logic [CapW-1:0] count_q;
  logic            end_q;

  logic            load;
  logic            is_data;
  logic            last;
  logic [7:0]      sel_byte;

  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign is_data = ({1'b0, idx_q} < {1'b0, job_i.nbytes});
  assign last    = job_i.status ? (idx_q == job_i.nbytes)
                                : ({1'b0, idx_q} + 3'd1 == {1'b0, job_i.nbytes});
  assign pop_o   = load && last;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = job_i.chunk[23:16];
      2'd1:    sel_byte = job_i.chunk[15:8];
      2'd2:    sel_byte = job_i.chunk[7:0];
      default: sel_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= is_data ? sel_byte : 8'd0;
      status_q <= !is_data;
      err_q    <= !is_data && job_i.err;
      count_q  <= is_data ? '0 : job_i.count;
      end_q    <= last;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign is_status_o    = status_q;
  assign decode_error_o = err_q;
  assign byte_count_o   = count_q;
  assign run_end_o      = end_q;

endmodule

FILE: src/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder.
// A result word reaches the outputs through the job queue and then the output register.
// Throughput: one character per cycle unless the job queue is full; the output register sends one
// word per cycle unless out_stall_i holds it, so a quantum's bytes leave one by one and the job queue absorbs bursts.
// Reset: asynchronous, active low; clears message state and the queue, capacity
// returns to 32767.
module base64_stream_decoder_top #(
  parameter int unsigned FifoDepth = bdec_pkg::FifoDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bdec_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                char_code_i,
  input  logic                      final_char_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      is_status_o,
  output logic                      decode_error_o,
  output logic [bdec_pkg::CapW-1:0] byte_count_o,
  output logic                      run_end_o
);
  import bdec_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  bdec_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .char_code_i,
    .final_char_i,
    .q_full_i (full),
    .push_o   (push),
    .job_o    (push_job)
  );

  bdec_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (full),
    .empty_o (empty)
  );

  bdec_back u_back (
    .clk_i,
    .rst_ni,
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .is_status_o,
    .decode_error_o,
    .byte_count_o,
    .run_end_o
  );

endmodule

FILE: src/bdec_checker.sv
// Port-level checks of the base64 stream decoder and their binding.
module bdec_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [7:0]                out_byte_o,
  input logic                      is_status_o,
  input logic                      decode_error_o,
  input logic [bdec_pkg::CapW-1:0] byte_count_o,
  input logic                      run_end_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_status_o) && $stable(decode_error_o) && $stable(byte_count_o)
      && $stable(run_end_o))
    else $error("stalled output word changed");

  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_status_o |-> run_end_o)
    else $error("status word without run end");

  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> is_status_o && byte_count_o == '0)
    else $error("error status carries a byte count");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_status_o |-> !decode_error_o && byte_count_o == '0)
    else $error("data word carries status fields");

endmodule

bind base64_stream_decoder_top bdec_checker u_bdec_checker (.*);
